FILE: rtl/core/lz_flag_mask_decompressor_unit_defines.svh
// Assertion macros for the LZ flag-mask decompressor.
// Included by RTL files that carry assertions; needs clk and rst in scope.
`ifndef LZ_FLAG_MASK_DECOMPRESSOR_UNIT_DEFINES_SVH
`define LZ_FLAG_MASK_DECOMPRESSOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define LZFD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LZFD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LZFD_ASSERT_IMP(label, ante, cons, msg)
`define LZFD_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

FILE: rtl/core/lzfd_pkg.sv
// Shared types and constants for the LZ flag-mask decompressor.
// No dependencies.
package lzfd_pkg;

  localparam int unsigned LANES = 4;

  localparam logic [3:0] HEADER_SKIP      = 4'd4;
  localparam logic [3:0] HEADER_SIZE_END  = 4'd8;
  localparam logic [3:0] HEADER_FLAG_LO   = 4'd8;
  localparam logic [3:0] HEADER_FLAG_HI   = 4'd9;
  localparam logic [3:0] HEADER_COUNT_MAX = 4'd15;
  localparam logic [3:0] FLAG_LAST        = 4'd15;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] lane0;
    logic [7:0] lane1;
    logic [7:0] lane2;
    logic [7:0] lane3;
    logic [2:0] lane_count;
    logic       last_in_run;
    logic       stream_end;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_TOKEN   = 3'd1,
    PH_LENGTH  = 3'd2,
    PH_FLAG_LO = 3'd3,
    PH_FLAG_HI = 3'd4
  } phase_t;

  typedef struct packed {
    logic       restart;
    logic       lit_we;
    logic [7:0] lit_byte;
    logic       copy_start;
    logic [7:0] copy_len;
    logic [7:0] copy_dist;
    logic       copy_ends;
  } hist_cmd_t;

endpackage

FILE: rtl/core/lzfd_history.sv
// History buffer: one write port, one registered read port.
// No dependencies.
module lzfd_history #(
  parameter int unsigned HISTORY_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(HISTORY_DEPTH)-1:0] waddr,
  input  logic [7:0]                       wdata,
  input  logic                             re,
  input  logic [$clog2(HISTORY_DEPTH)-1:0] raddr,
  output logic [7:0]                       rdata
);

  logic [7:0] mem [HISTORY_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/lzfd_parser.sv
// Stream parser: header, flag words, tokens, output count and end detect.
// Depends on lzfd_pkg.
module lzfd_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  lzfd_pkg::in_item_t  in_data,
  output lzfd_pkg::hist_cmd_t cmd,
  output logic                res_valid,
  output lzfd_pkg::out_item_t res
);

  lzfd_pkg::phase_t phase, phase_next, e_phase;
  logic [3:0]  header_count, header_count_next, e_hc;
  logic [31:0] stream_size, stream_size_next, e_size;
  logic [31:0] produced_count, produced_count_next, e_prod;
  logic [15:0] flag_word, flag_word_next, e_fw;
  logic [3:0]  flag_position, flag_position_next, e_fp;
  logic [7:0]  match_distance, match_distance_next, e_dist;
  logic        finished, finished_next, e_fin;

  logic        start, active, is_match;
  logic [7:0]  b;
  logic [31:0] addend, sum_sat;
  logic [32:0] sum;
  logic        ends;
  logic [3:0]  fp_after;

  assign b      = in_data.in_byte;
  assign start  = accept && in_data.start_of_stream;

  always_comb begin
    e_phase = phase;
    e_hc    = header_count;
    e_size  = stream_size;
    e_prod  = produced_count;
    e_fw    = flag_word;
    e_fp    = flag_position;
    e_dist  = match_distance;
    e_fin   = finished;
    if (start) begin
      e_phase = lzfd_pkg::PH_HEADER;
      e_hc    = '0;
      e_size  = '0;
      e_prod  = '0;
      e_fw    = '0;
      e_fp    = '0;
      e_dist  = '0;
      e_fin   = 1'b0;
    end
  end

  assign active   = accept && !e_fin;
  assign is_match = e_fw[e_fp];
  assign addend   = (e_phase == lzfd_pkg::PH_LENGTH) ? {24'd0, b} : 32'd1;
  assign sum      = {1'b0, e_prod} + {1'b0, addend};
  assign sum_sat  = sum[32] ? '1 : sum[31:0];
  assign ends     = sum_sat >= e_size;
  assign fp_after = (e_fp >= lzfd_pkg::FLAG_LAST) ? 4'd0 : e_fp + 4'd1;

  always_comb begin
    phase_next = e_phase;
    if (active) begin
      unique case (e_phase)
        lzfd_pkg::PH_HEADER: begin
          if (e_hc == lzfd_pkg::HEADER_FLAG_HI) phase_next = lzfd_pkg::PH_TOKEN;
        end
        lzfd_pkg::PH_FLAG_LO: phase_next = lzfd_pkg::PH_FLAG_HI;
        lzfd_pkg::PH_FLAG_HI: phase_next = lzfd_pkg::PH_TOKEN;
        lzfd_pkg::PH_TOKEN: begin
          if (is_match) begin
            phase_next = lzfd_pkg::PH_LENGTH;
          end else begin
            phase_next = (e_fp >= lzfd_pkg::FLAG_LAST) ? lzfd_pkg::PH_FLAG_LO
                                                       : lzfd_pkg::PH_TOKEN;
          end
        end
        lzfd_pkg::PH_LENGTH: begin
          phase_next = (e_fp >= lzfd_pkg::FLAG_LAST) ? lzfd_pkg::PH_FLAG_LO
                                                     : lzfd_pkg::PH_TOKEN;
        end
        default: phase_next = lzfd_pkg::PH_TOKEN;
      endcase
    end
  end

  always_comb begin
    header_count_next   = e_hc;
    stream_size_next    = e_size;
    produced_count_next = e_prod;
    flag_word_next      = e_fw;
    flag_position_next  = e_fp;
    match_distance_next = e_dist;
    finished_next       = e_fin;
    cmd                 = '0;
    cmd.restart         = start;
    res_valid           = 1'b0;
    res                 = '0;
    if (active) begin
      unique case (e_phase)
        lzfd_pkg::PH_HEADER: begin
          if (e_hc >= lzfd_pkg::HEADER_SKIP && e_hc < lzfd_pkg::HEADER_SIZE_END) begin
            stream_size_next[{e_hc[1:0], 3'b000} +: 8] = b;
          end else if (e_hc == lzfd_pkg::HEADER_FLAG_LO) begin
            flag_word_next = {8'd0, b};
          end else if (e_hc == lzfd_pkg::HEADER_FLAG_HI) begin
            flag_word_next     = {b, e_fw[7:0]};
            flag_position_next = '0;
          end
          if (e_hc < lzfd_pkg::HEADER_COUNT_MAX) header_count_next = e_hc + 4'd1;
        end
        lzfd_pkg::PH_FLAG_LO: flag_word_next = {8'd0, b};
        lzfd_pkg::PH_FLAG_HI: begin
          flag_word_next     = {b, e_fw[7:0]};
          flag_position_next = '0;
        end
        lzfd_pkg::PH_TOKEN: begin
          if (is_match) begin
            match_distance_next = b;
          end else begin
            produced_count_next = sum_sat;
            flag_position_next  = fp_after;
            finished_next       = e_fin | ends;
            cmd.lit_we          = 1'b1;
            cmd.lit_byte        = b;
            res_valid           = 1'b1;
            res.lane0           = b;
            res.lane_count      = 3'd1;
            res.last_in_run     = 1'b1;
            res.stream_end      = ends;
          end
        end
        lzfd_pkg::PH_LENGTH: begin
          produced_count_next = sum_sat;
          flag_position_next  = fp_after;
          finished_next       = e_fin | ends;
          cmd.copy_start      = (b != 8'd0);
          cmd.copy_len        = b;
          cmd.copy_dist       = e_dist;
          cmd.copy_ends       = ends;
          if (b == 8'd0 && ends) begin
            res_valid       = 1'b1;
            res.last_in_run = 1'b1;
            res.stream_end  = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= lzfd_pkg::PH_HEADER;
      header_count   <= '0;
      stream_size    <= '0;
      produced_count <= '0;
      flag_word      <= '0;
      flag_position  <= '0;
      match_distance <= '0;
      finished       <= 1'b1;
    end else begin
      phase          <= phase_next;
      header_count   <= header_count_next;
      stream_size    <= stream_size_next;
      produced_count <= produced_count_next;
      flag_word      <= flag_word_next;
      flag_position  <= flag_position_next;
      match_distance <= match_distance_next;
      finished       <= finished_next;
    end
  end

endmodule

FILE: rtl/core/lzfd_copy.sv
// Match copy engine: owns the history write pointer, issues reads,
// writes copied bytes back and packs them into lane results.
// Depends on lzfd_pkg and the assertion macro header.
`include "lz_flag_mask_decompressor_unit_defines.svh"
module lzfd_copy #(
  parameter int unsigned HISTORY_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lzfd_pkg::hist_cmd_t                 cmd,
  input  logic                                out_free,
  output logic                                busy,
  output logic                                res_valid,
  output lzfd_pkg::out_item_t                 res,
  output logic                                mem_we,
  output logic [$clog2(HISTORY_DEPTH)-1:0]    mem_waddr,
  output logic [7:0]                          mem_wdata,
  output logic                                mem_re,
  output logic [$clog2(HISTORY_DEPTH)-1:0]    mem_raddr,
  input  logic [7:0]                          mem_rdata
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW-1:0] PTR_LAST = AW'(HISTORY_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(HISTORY_DEPTH);

  logic [AW-1:0] wptr, ipos;
  logic          wrapped, iwrapped;
  logic [7:0]    rem, match_dist, last_byte;
  logic          ends, rd_valid, rd_zero, rd_fwd, rd_last;
  logic [1:0]    fill;
  logic [7:0]    lanes [lzfd_pkg::LANES];

  logic          completes, advance, issue, copy_we;
  logic [7:0]    v;
  logic [AW:0]   dist_w, ipos_w, rd_full;
  logic          src_zero;
  logic [7:0]    res_lanes [lzfd_pkg::LANES];

  assign busy      = (rem != 8'd0) || rd_valid;
  assign completes = (fill == 2'd3) || rd_last;
  assign advance   = !(rd_valid && completes && !out_free);
  assign issue     = advance && (rem != 8'd0);
  assign copy_we   = rd_valid && advance;

  assign dist_w   = (AW + 1)'(match_dist);
  assign ipos_w   = {1'b0, ipos};
  assign rd_full  = (ipos_w >= dist_w) ? ipos_w - dist_w : ipos_w + DEPTH_W - dist_w;
  assign src_zero = (match_dist == 8'd0) || (!iwrapped && dist_w > ipos_w);

  assign v = rd_zero ? 8'd0 : (rd_fwd ? last_byte : mem_rdata);

  assign mem_we    = cmd.lit_we || copy_we;
  assign mem_waddr = wptr;
  assign mem_wdata = cmd.lit_we ? cmd.lit_byte : v;
  assign mem_re    = issue;
  assign mem_raddr = rd_full[AW-1:0];

  always_comb begin
    for (int j = 0; j < lzfd_pkg::LANES; j++) begin
      if (j < int'(fill)) res_lanes[j] = lanes[j];
      else if (j == int'(fill)) res_lanes[j] = v;
      else res_lanes[j] = 8'd0;
    end
  end

  assign res_valid       = copy_we && completes;
  assign res.lane0       = res_lanes[0];
  assign res.lane1       = res_lanes[1];
  assign res.lane2       = res_lanes[2];
  assign res.lane3       = res_lanes[3];
  assign res.lane_count  = {1'b0, fill} + 3'd1;
  assign res.last_in_run = rd_last;
  assign res.stream_end  = rd_last && ends;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr     <= '0;
      wrapped  <= 1'b0;
      ipos     <= '0;
      iwrapped <= 1'b0;
      rem      <= '0;
      rd_valid <= 1'b0;
      fill     <= '0;
    end else begin
      if (cmd.restart) begin
        wptr    <= '0;
        wrapped <= 1'b0;
      end else if (mem_we) begin
        wptr    <= (wptr == PTR_LAST) ? '0 : wptr + AW'(1);
        wrapped <= wrapped | (wptr == PTR_LAST);
      end
      if (cmd.copy_start) begin
        rem      <= cmd.copy_len;
        ipos     <= wptr;
        iwrapped <= wrapped;
      end else if (issue) begin
        rem      <= rem - 8'd1;
        ipos     <= (ipos == PTR_LAST) ? '0 : ipos + AW'(1);
        iwrapped <= iwrapped | (ipos == PTR_LAST);
      end
      if (advance) begin
        rd_valid <= issue;
      end
      if (copy_we) begin
        fill <= completes ? 2'd0 : fill + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.copy_start) begin
      match_dist <= cmd.copy_dist;
      ends       <= cmd.copy_ends;
    end
    if (issue) begin
      rd_zero <= src_zero;
      rd_fwd  <= (match_dist == 8'd1) && rd_valid;
      rd_last <= (rem == 8'd1);
    end
    if (copy_we) begin
      last_byte     <= v;
      lanes[fill]   <= v;
    end
  end

  `LZFD_ASSERT_IMP(a_res_slot_free, res_valid, out_free, "copy result into full output")
  `LZFD_ASSERT_IMP(a_copy_start_idle, cmd.copy_start, !busy, "copy started while busy")
  `LZFD_ASSERT_IMP(a_literal_idle, cmd.lit_we, !busy, "literal written during copy")
  `LZFD_ASSERT_NXT(a_stall_holds, busy && !advance, $stable(rem) && $stable(fill), "stall moved copy")

endmodule

FILE: rtl/core/lz_flag_mask_decompressor_unit.sv
// LZ flag-mask decompressor top level: parser, copy engine, history, output register.
// Header, flag and literal bytes: one per cycle unless output stalls; result next cycle.
// A match of length L>0 holds the input during its copy and output stalls: one read per byte.
// Results of up to four bytes leave through a single output register.
// Synchronous reset: idle until a request with start_of_stream; history not cleared.
module lz_flag_mask_decompressor_unit #(
  parameter int unsigned HISTORY_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lzfd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lzfd_pkg::out_item_t out_data
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);

  lzfd_pkg::hist_cmd_t cmd;
  lzfd_pkg::out_item_t p_res, e_res;
  logic                p_res_valid, e_res_valid;
  logic                accept, out_free, busy;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [7:0]          mem_wdata, mem_rdata;

  assign out_free = !out_valid || out_ready;
  assign in_ready = !busy && out_free;
  assign accept   = in_valid && in_ready;

  lzfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_data   (in_data),
    .cmd       (cmd),
    .res_valid (p_res_valid),
    .res       (p_res)
  );

  lzfd_copy #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_copy (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .out_free  (out_free),
    .busy      (busy),
    .res_valid (e_res_valid),
    .res       (e_res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  lzfd_history #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= p_res_valid || e_res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= e_res_valid ? e_res : p_res;
    end
  end

endmodule

FILE: tb/sv/lzfd_expand_checker.sv
// Checker for the LZ flag-mask decompressor: watches both channels,
// predicts the decoded results and compares them in order.
// Depends on lzfd_pkg for the request and result types and the header constants.
module lzfd_expand_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  lzfd_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  lzfd_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lzfd_pkg::*;

  localparam int HIST_DEPTH = 256;
  localparam int MAX_REPORTS = 10;

  logic [7:0]  hist [HIST_DEPTH];
  logic [7:0]  wr_ptr;
  logic [3:0]  hdr_cnt;
  logic [31:0] stream_len;
  logic [31:0] produced;
  logic [15:0] flags;
  logic [3:0]  flag_pos;
  phase_t      phase;
  logic [7:0]  match_off;
  logic        done;
  logic [7:0]  lane_buf [LANES];
  out_item_t   decoded_q [$];
  int          errs;

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic string fmt_result(out_item_t r);
    return $sformatf("lanes %h %h %h %h cnt %0d last %b end %b",
                     r.lane0, r.lane1, r.lane2, r.lane3, r.lane_count,
                     r.last_in_run, r.stream_end);
  endfunction

  task automatic begin_stream();
    foreach (hist[i]) hist[i] = 8'h00;
    wr_ptr = '0;
    hdr_cnt = '0;
    stream_len = '0;
    produced = '0;
    flags = '0;
    flag_pos = '0;
    phase = PH_HEADER;
    match_off = '0;
    done = 1'b0;
  endtask

  task automatic push_result(int cnt, logic last, logic fin);
    out_item_t r;
    r.lane0 = (cnt > 0) ? lane_buf[0] : 8'h00;
    r.lane1 = (cnt > 1) ? lane_buf[1] : 8'h00;
    r.lane2 = (cnt > 2) ? lane_buf[2] : 8'h00;
    r.lane3 = (cnt > 3) ? lane_buf[3] : 8'h00;
    r.lane_count = 3'(cnt);
    r.last_in_run = last;
    r.stream_end = fin;
    decoded_q.push_back(r);
  endtask

  task automatic close_token(logic ends);
    if (flag_pos == FLAG_LAST) begin
      flag_pos = '0;
      phase = PH_FLAG_LO;
    end else begin
      flag_pos = flag_pos + 4'd1;
      phase = PH_TOKEN;
    end
    if (ends) done = 1'b1;
  endtask

  task automatic decode_byte(in_item_t req);
    logic [7:0] b;
    logic [7:0] v;
    logic [7:0] rd;
    logic       ends;
    int         len;
    int         fill;
    int         i;
    b = req.in_byte;
    if (req.start_of_stream) begin_stream();
    if (!done) begin
      case (phase)
        PH_HEADER: begin
          if (hdr_cnt >= HEADER_SKIP && hdr_cnt < HEADER_SIZE_END)
            stream_len = stream_len | (32'(b) << (8 * (hdr_cnt - HEADER_SKIP)));
          else if (hdr_cnt == HEADER_FLAG_LO)
            flags = {8'h00, b};
          else if (hdr_cnt == HEADER_FLAG_HI) begin
            flags[15:8] = b;
            flag_pos = '0;
            phase = PH_TOKEN;
          end
          if (hdr_cnt < HEADER_COUNT_MAX) hdr_cnt = hdr_cnt + 4'd1;
        end
        PH_FLAG_LO: begin
          flags = {8'h00, b};
          phase = PH_FLAG_HI;
        end
        PH_FLAG_HI: begin
          flags[15:8] = b;
          flag_pos = '0;
          phase = PH_TOKEN;
        end
        PH_TOKEN: begin
          if (flags[flag_pos]) begin
            match_off = b;
            phase = PH_LENGTH;
          end else begin
            hist[wr_ptr] = b;
            wr_ptr = wr_ptr + 8'd1;
            produced = add_sat(produced, 32'd1);
            ends = produced >= stream_len;
            lane_buf[0] = b;
            push_result(1, 1'b1, ends);
            close_token(ends);
          end
        end
        PH_LENGTH: begin
          len = int'(b);
          fill = 0;
          produced = add_sat(produced, 32'(b));
          ends = produced >= stream_len;
          for (i = 0; i < len; i++) begin
            rd = wr_ptr - match_off;
            v = (match_off != 8'h00) ? hist[rd] : 8'h00;
            hist[wr_ptr] = v;
            wr_ptr = wr_ptr + 8'd1;
            lane_buf[fill] = v;
            fill++;
            if (fill == LANES || i + 1 == len) begin
              push_result(fill, i + 1 == len, (i + 1 == len) && ends);
              fill = 0;
            end
          end
          // zero-length match that closes the stream still reports the end
          if (len == 0 && ends) push_result(0, 1'b1, 1'b1);
          close_token(ends);
        end
        default: phase = PH_TOKEN;
      endcase
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      begin_stream();
      done = 1'b1;
      decoded_q.delete();
      errs = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          errs++;
          if (errs <= MAX_REPORTS)
            $display("%0t: unexpected result: %s", $time, fmt_result(out_data));
        end else begin
          want = decoded_q.pop_front();
          if (out_data.lane0 !== want.lane0 || out_data.lane1 !== want.lane1 ||
              out_data.lane2 !== want.lane2 || out_data.lane3 !== want.lane3 ||
              out_data.lane_count !== want.lane_count ||
              out_data.last_in_run !== want.last_in_run ||
              out_data.stream_end !== want.stream_end) begin
            errs++;
            if (errs <= MAX_REPORTS)
              $display("%0t: mismatch: expected %s, got %s", $time,
                       fmt_result(want), fmt_result(out_data));
          end
        end
      end
      if (in_valid && in_ready) decode_byte(in_data);
    end
    fail_count <= errs;
    pending <= decoded_q.size();
  end

endmodule

FILE: tb/sv/testbench.sv
// Top of the decompressor testbench: clock, reset, byte-stream stimulus with
// random idling on both channels, watchdog and verdict.
// Depends on lzfd_pkg, lz_flag_mask_decompressor_unit and lzfd_expand_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lzfd_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 300;
  localparam int TARGET_ITEMS = 230;
  localparam int MAX_TOKENS = 64;

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        pending;
  int        idle_cycles = 0;
  int        out_hold = 0;
  int        sent_items = 0;
  bit        calm = 1'b0;
  in_item_t  stream_q [$];

  lz_flag_mask_decompressor_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  lzfd_expand_checker decode_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  always @(posedge clk) begin
    if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold <= out_hold - 1;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) out_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles", IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_byte(logic [7:0] b, logic s);
    stream_q.push_back('{in_byte: b, start_of_stream: s});
  endtask

  task automatic push_word32(logic [31:0] w);
    push_byte(w[7:0], 1'b0);
    push_byte(w[15:8], 1'b0);
    push_byte(w[23:16], 1'b0);
    push_byte(w[31:24], 1'b0);
  endtask

  function automatic logic [15:0] group_flags(int g, int n_tok, bit is_match [MAX_TOKENS]);
    logic [15:0] fw;
    int          j;
    fw = 16'($urandom);
    for (j = 0; j < 16; j++)
      if (g * 16 + j < n_tok) fw[j] = is_match[g * 16 + j];
    return fw;
  endfunction

  function automatic logic [7:0] pick_offset();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'h00;
    if (r < 70) return 8'($urandom_range(1, 8));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'h00;
    if (r < 85) return 8'($urandom_range(1, 12));
    if (r < 95) return 8'($urandom_range(13, 64));
    if (r < 98) return 8'($urandom_range(65, 254));
    return 8'hFF;
  endfunction

  // builds one stream: header, tokens up to the end the size implies,
  // sometimes cut short or left open so the next start lands mid-stream
  task automatic build_stream(output int counted);
    bit          is_match [MAX_TOKENS];
    logic [7:0]  tok_off [MAX_TOKENS];
    logic [7:0]  tok_len [MAX_TOKENS];
    logic [31:0] cum [MAX_TOKENS + 1];
    logic [31:0] stream_len;
    logic [15:0] fw;
    int          mode;
    int          n_tok;
    int          fin_tok;
    int          end_tok;
    int          k;
    int          span;
    bit          ended;
    mode = $urandom_range(0, 9);
    n_tok = (mode == 2) ? $urandom_range(16, 24) :
            ($urandom_range(0, 3) == 0) ? $urandom_range(17, 40) : $urandom_range(2, 16);
    cum[0] = '0;
    for (k = 0; k < n_tok; k++) begin
      is_match[k] = $urandom_range(0, 1);
      tok_off[k] = pick_offset();
      tok_len[k] = pick_length();
      cum[k + 1] = cum[k] + (is_match[k] ? 32'(tok_len[k]) : 32'd1);
    end
    if (mode == 0) begin
      stream_len = '0;
    end else if (mode == 1) begin
      stream_len = {1'b1, 31'($urandom)};
    end else begin
      fin_tok = (mode == 2) ? 16 : $urandom_range(1, n_tok);
      span = int'(cum[fin_tok] - cum[fin_tok - 1]);
      stream_len = cum[fin_tok] - ((span > 0) ? 32'($urandom_range(0, span - 1)) : 32'd0);
    end
    ended = 1'b0;
    end_tok = n_tok;
    for (k = 0; k < n_tok && !ended; k++)
      if (cum[k + 1] >= stream_len) begin
        ended = 1'b1;
        end_tok = k + 1;
      end

    stream_q.delete();
    push_byte(8'($urandom), 1'b1);
    for (k = 0; k < 3; k++) push_byte(8'($urandom), 1'b0);
    push_word32(stream_len);
    fw = group_flags(0, n_tok, is_match);
    push_byte(fw[7:0], 1'b0);
    push_byte(fw[15:8], 1'b0);
    for (k = 0; k < end_tok; k++) begin
      if (k > 0 && k % 16 == 0) begin
        fw = group_flags(k / 16, n_tok, is_match);
        push_byte(fw[7:0], 1'b0);
        push_byte(fw[15:8], 1'b0);
      end
      if (is_match[k]) begin
        push_byte(tok_off[k], 1'b0);
        push_byte(tok_len[k], 1'b0);
      end else begin
        push_byte(8'($urandom), 1'b0);
      end
    end
    if ($urandom_range(0, 11) == 0) begin
      k = $urandom_range(1, stream_q.size() - 1);
      while (stream_q.size() > k) void'(stream_q.pop_back());
    end else begin
      if (ended)
        repeat ($urandom_range(0, 4)) push_byte(8'($urandom), 1'b0);
    end
    counted = stream_q.size();
  endtask

  task automatic send_item(in_item_t req);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_stream();
    foreach (stream_q[i]) send_item(stream_q[i]);
  endtask

  initial begin
    int counted;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // idle byte, size-zero stream ending on an empty match, ignored byte,
    // then an open stream with all-ones fields and a full-length match
    stream_q.delete();
    push_byte(8'h5A, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_word32(32'h0000_0000);
    push_byte(8'h01, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
    repeat (3) push_byte(8'hFF, 1'b0);
    push_word32(32'hFFFF_FFFF);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    send_stream();
    sent_items = stream_q.size();

    while (sent_items < TARGET_ITEMS) begin
      calm <= ($urandom_range(0, 4) == 0);
      build_stream(counted);
      send_stream();
      sent_items += counted;
    end
    in_valid <= 1'b0;
    calm <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
